>>> rtl/core/nfab_pkg.sv
// Shared types and constants of the postfix regular expression to NFA builder.
package nfab_pkg;

   localparam int NFAB_MAX_STATES  = 256;
   localparam int NFAB_STACK_DEPTH = 32;
   localparam int NFAB_QUEUE_DEPTH = 2;

   localparam logic [7:0] SYM_CAT  = 8'h2E;
   localparam logic [7:0] SYM_ALT  = 8'h7C;
   localparam logic [7:0] SYM_STAR = 8'h2A;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_LEFTOVER  = 3'd3;
   localparam logic [2:0] ST_NOROOM    = 3'd4;

   localparam logic REC_EDGE = 1'b0;
   localparam logic REC_DONE = 1'b1;

   typedef enum logic [2:0] {
      OP_LIT,
      OP_CAT,
      OP_ALT,
      OP_STAR,
      OP_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] symbol;
   } cmd_type;

   typedef struct packed {
      logic       rec_type;
      logic [7:0] from_state;
      logic [7:0] to_state;
      logic [7:0] label;
      logic       is_epsilon;
      logic [7:0] start_state;
      logic [7:0] final_state;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'b001,
      BK_FETCH = 3'b010,
      BK_EMIT  = 3'b100
   } back_state_type;

endpackage

>>> rtl/core/nfab_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nfab_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/nfab_front.sv
// Front end: takes requests, classifies the symbol and queues the command.
module nfab_front import nfab_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_symbol,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);

   localparam int QAW = (NFAB_QUEUE_DEPTH > 1) ? $clog2(NFAB_QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(NFAB_QUEUE_DEPTH + 1);
   localparam logic [QAW-1:0] PTR_LAST = QAW'(NFAB_QUEUE_DEPTH - 1);
   localparam logic [QCW-1:0] FILL_FULL = QCW'(NFAB_QUEUE_DEPTH);

   cmd_type        q_ff [NFAB_QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] fill_ff, fill_in;
   cmd_type        cls;
   logic           push;
   logic           pop;

   always_comb begin
      cls.symbol = req_symbol;
      priority if (req_kind) begin
         cls.op = OP_END;
      end else if (req_symbol == SYM_CAT) begin
         cls.op = OP_CAT;
      end else if (req_symbol == SYM_ALT) begin
         cls.op = OP_ALT;
      end else if (req_symbol == SYM_STAR) begin
         cls.op = OP_STAR;
      end else begin
         cls.op = OP_LIT;
      end
   end

   assign req_ready = (fill_ff != FILL_FULL);
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> rtl/core/nfab_back.sv
// Back end: fragment stack, state counter, edge emission and result register.
module nfab_back import nfab_pkg::*; #(
   parameter int MAX_STATES  = NFAB_MAX_STATES,
   parameter int STACK_DEPTH = NFAB_STACK_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int SW = $clog2(MAX_STATES);
   localparam int NW = $clog2(MAX_STATES + 1);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int FW = 2 * SW;
   localparam logic [NW-1:0] ROOM_MAX   = NW'(MAX_STATES - 2);
   localparam logic [CW-1:0] STACK_FULL = CW'(STACK_DEPTH);

   function automatic logic [7:0] to_byte(input logic [SW-1:0] v);
      logic [SW+7:0] w;
      w = {8'b0, v};
      return w[7:0];
   endfunction

   back_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [NW-1:0]  next_ff, next_in;
   logic [2:0]     err_ff, err_in;
   logic [SW-1:0]  tos_start_ff, tos_start_in;
   logic [SW-1:0]  tos_fin_ff, tos_fin_in;
   op_type         op_ff, op_in;
   logic [1:0]     step_ff, step_in;
   logic [SW-1:0]  s_ff, s_in;
   logic [SW-1:0]  a_start_ff, a_start_in;
   logic [SW-1:0]  a_fin_ff, a_fin_in;
   logic [SW-1:0]  b_start_ff, b_start_in;
   logic [SW-1:0]  b_fin_ff, b_fin_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           out_free;
   logic           load;
   logic           room;
   logic [SW-1:0]  new_s;
   logic [SW-1:0]  e_emit;
   logic [CW-1:0]  cnt_m1;
   logic [CW-1:0]  cnt_m2;
   logic           ram_wr_en;
   logic           ram_rd_en;
   logic [FW-1:0]  ram_rd_data;
   logic [SW-1:0]  nos_start;
   logic [SW-1:0]  nos_fin;
   logic [SW-1:0]  edge_from;
   logic [SW-1:0]  edge_to;
   logic [1:0]     last_step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign room      = (next_ff <= ROOM_MAX);
   assign new_s     = next_ff[SW-1:0];
   assign e_emit    = s_ff + 1'b1;
   assign cnt_m1    = count_ff - CW'(1);
   assign cnt_m2    = count_ff - CW'(2);
   assign nos_start = ram_rd_data[FW-1:SW];
   assign nos_fin   = ram_rd_data[SW-1:0];

   // Fragments below the top of stack live in the RAM; the top is in registers.
   nfab_ram #(
      .WIDTH (FW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_m1[AW-1:0]),
      .wr_data ({tos_start_ff, tos_fin_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_m2[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      edge_from = s_ff;
      edge_to   = a_start_ff;
      last_step = 2'd3;
      unique case (op_ff)
         OP_CAT: begin
            edge_from = a_fin_ff;
            edge_to   = b_start_ff;
            last_step = 2'd0;
         end
         OP_ALT: begin
            unique case (step_ff)
               2'd0: begin edge_from = s_ff;     edge_to = a_start_ff; end
               2'd1: begin edge_from = s_ff;     edge_to = b_start_ff; end
               2'd2: begin edge_from = a_fin_ff; edge_to = e_emit;     end
               2'd3: begin edge_from = b_fin_ff; edge_to = e_emit;     end
               default: ;
            endcase
         end
         OP_STAR: begin
            unique case (step_ff)
               2'd0: begin edge_from = s_ff;     edge_to = a_start_ff; end
               2'd1: begin edge_from = s_ff;     edge_to = e_emit;     end
               2'd2: begin edge_from = a_fin_ff; edge_to = a_start_ff; end
               2'd3: begin edge_from = a_fin_ff; edge_to = e_emit;     end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      err_in       = err_ff;
      tos_start_in = tos_start_ff;
      tos_fin_in   = tos_fin_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      s_in         = s_ff;
      a_start_in   = a_start_ff;
      a_fin_in     = a_fin_ff;
      b_start_in   = b_start_ff;
      b_fin_in     = b_fin_ff;
      cmd_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      load         = 1'b0;
      rsp_in       = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_END) begin
                  if (out_free) begin
                     cmd_ready       = 1'b1;
                     load            = 1'b1;
                     rsp_in.rec_type = REC_DONE;
                     rsp_in.last     = 1'b1;
                     priority if (err_ff != ST_OK) begin
                        rsp_in.status = err_ff;
                     end else if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (count_ff != CW'(1)) begin
                        rsp_in.status = ST_LEFTOVER;
                     end else begin
                        rsp_in.status      = ST_OK;
                        rsp_in.start_state = to_byte(tos_start_ff);
                        rsp_in.final_state = to_byte(tos_fin_ff);
                     end
                     count_in = '0;
                     next_in  = '0;
                     err_in   = ST_OK;
                  end
               end else if (err_ff != ST_OK) begin
                  // Symbols after an error are dropped until the end marker.
                  cmd_ready = 1'b1;
               end else begin
                  unique case (cmd.op)
                     OP_LIT: begin
                        if (!room || count_ff == STACK_FULL) begin
                           cmd_ready = 1'b1;
                           err_in    = ST_NOROOM;
                        end else if (out_free) begin
                           cmd_ready         = 1'b1;
                           load              = 1'b1;
                           rsp_in.rec_type   = REC_EDGE;
                           rsp_in.from_state = to_byte(new_s);
                           rsp_in.to_state   = to_byte(new_s + 1'b1);
                           rsp_in.label      = cmd.symbol;
                           rsp_in.last       = 1'b1;
                           ram_wr_en         = (count_ff != '0);
                           tos_start_in      = new_s;
                           tos_fin_in        = new_s + 1'b1;
                           count_in          = count_ff + 1'b1;
                           next_in           = next_ff + NW'(2);
                        end
                     end
                     OP_STAR: begin
                        cmd_ready = 1'b1;
                        if (count_ff == '0) begin
                           err_in = ST_UNDERFLOW;
                        end else if (!room) begin
                           err_in = ST_NOROOM;
                        end else begin
                           op_in        = OP_STAR;
                           step_in      = 2'd0;
                           s_in         = new_s;
                           a_start_in   = tos_start_ff;
                           a_fin_in     = tos_fin_ff;
                           tos_start_in = new_s;
                           tos_fin_in   = new_s + 1'b1;
                           next_in      = next_ff + NW'(2);
                           state_in     = BK_EMIT;
                        end
                     end
                     OP_CAT, OP_ALT: begin
                        cmd_ready = 1'b1;
                        if (count_ff < CW'(2)) begin
                           err_in = ST_UNDERFLOW;
                        end else if (cmd.op == OP_ALT && !room) begin
                           err_in = ST_NOROOM;
                        end else begin
                           ram_rd_en = 1'b1;
                           op_in     = cmd.op;
                           step_in   = 2'd0;
                           state_in  = BK_FETCH;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end

         BK_FETCH: begin
            // The fragment below the top has arrived from the stack RAM.
            a_start_in = nos_start;
            a_fin_in   = nos_fin;
            b_start_in = tos_start_ff;
            b_fin_in   = tos_fin_ff;
            count_in   = cnt_m1;
            if (op_ff == OP_ALT) begin
               s_in         = new_s;
               tos_start_in = new_s;
               tos_fin_in   = new_s + 1'b1;
               next_in      = next_ff + NW'(2);
            end else begin
               tos_start_in = nos_start;
            end
            state_in = BK_EMIT;
         end

         BK_EMIT: begin
            if (out_free) begin
               load              = 1'b1;
               rsp_in.rec_type   = REC_EDGE;
               rsp_in.from_state = to_byte(edge_from);
               rsp_in.to_state   = to_byte(edge_to);
               rsp_in.is_epsilon = 1'b1;
               rsp_in.last       = (step_ff == last_step);
               if (step_ff == last_step) begin
                  state_in = BK_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         next_ff      <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_start_ff <= tos_start_in;
      tos_fin_ff   <= tos_fin_in;
      op_ff        <= op_in;
      step_ff      <= step_in;
      s_ff         <= s_in;
      a_start_ff   <= a_start_in;
      a_fin_ff     <= a_fin_in;
      b_start_ff   <= b_start_in;
      b_fin_ff     <= b_fin_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> rtl/core/postfix_regex_to_nfa_builder_top.sv
// Top level of the postfix regular expression to NFA builder.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  req_kind, req_symbol
//   rsp_      out        rsp_valid / rsp_ready  rsp_rec_type ... rsp_last (one edge or done)
//
// The front end queues up to two classified requests, so requests keep flowing while the
// back end works. The back end issues each request from idle; concatenation and union then
// read the fragment below the top from the stack RAM, and every edge goes out in turn
// through the single result register, which a low rsp_ready can stall.
// Reset is synchronous and active high; it empties the queue and the stack, and the
// stack RAM needs no clearing since only entries below the fill count are read.
// A stalled rsp_ready holds the current result and, once the queue fills, req_ready.
module postfix_regex_to_nfa_builder_top import nfab_pkg::*; #(
   parameter int MAX_STATES  = NFAB_MAX_STATES,
   parameter int STACK_DEPTH = NFAB_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_rec_type,
   output logic [7:0] rsp_from_state,
   output logic [7:0] rsp_to_state,
   output logic [7:0] rsp_label,
   output logic       rsp_is_epsilon,
   output logic [7:0] rsp_start_state,
   output logic [7:0] rsp_final_state,
   output logic [2:0] rsp_status,
   output logic       rsp_last
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;
   rsp_type rsp;

   nfab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_symbol (req_symbol),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   nfab_back #(
      .MAX_STATES  (MAX_STATES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_rec_type    = rsp.rec_type;
   assign rsp_from_state  = rsp.from_state;
   assign rsp_to_state    = rsp.to_state;
   assign rsp_label       = rsp.label;
   assign rsp_is_epsilon  = rsp.is_epsilon;
   assign rsp_start_state = rsp.start_state;
   assign rsp_final_state = rsp.final_state;
   assign rsp_status      = rsp.status;
   assign rsp_last        = rsp.last;

endmodule

>>> sim/nfab_record_checker.sv
// Checker for the NFA builder: predicts edge and done records from requests and compares them.
`timescale 1ns / 100ps

module nfab_record_checker import nfab_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_symbol,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_rec_type,
   input  logic [7:0] rsp_from_state,
   input  logic [7:0] rsp_to_state,
   input  logic [7:0] rsp_label,
   input  logic       rsp_is_epsilon,
   input  logic [7:0] rsp_start_state,
   input  logic [7:0] rsp_final_state,
   input  logic [2:0] rsp_status,
   input  logic       rsp_last,
   output int         mismatches,
   output int         pending,
   output int         edge_total,
   output int         done_total,
   output logic [4:0] status_seen
);

   localparam int REPORT_LIMIT = 100;
   localparam int PEND_DEPTH   = 64;

   // Shadow copy of the fragment stack and the state counter.
   logic [8:0] frag_start [NFAB_STACK_DEPTH];
   logic [8:0] frag_final [NFAB_STACK_DEPTH];
   int         frag_count;
   int         next_free;
   logic [2:0] build_error;

   // Expected records in arrival order, kept in a ring.
   rsp_type    pend_ring [PEND_DEPTH];
   int         pend_head   = 0;
   int         pend_tail   = 0;
   int         pend_used   = 0;
   int         fail_count  = 0;
   int         record_no   = 0;
   int         edges_made  = 0;
   int         dones_made  = 0;
   logic [4:0] statuses    = '0;

   task automatic clear_model();
      frag_count  = 0;
      next_free   = 0;
      build_error = ST_OK;
   endtask

   function automatic rsp_type edge_record(input logic [8:0] src, input logic [8:0] dst,
                                           input logic [7:0] lab, input logic eps);
      rsp_type r;
      r            = '0;
      r.rec_type   = REC_EDGE;
      r.from_state = src[7:0];
      r.to_state   = dst[7:0];
      r.label      = lab;
      r.is_epsilon = eps;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < REPORT_LIMIT) begin
         $display("%0t ns: record %0d: %s", $time, record_no, msg);
      end
      fail_count++;
   endtask

   task automatic add_expected(input rsp_type r);
      if (pend_used >= PEND_DEPTH) begin
         report_mismatch("too many records outstanding");
      end else begin
         pend_ring[pend_tail] = r;
         pend_tail            = (pend_tail + 1) % PEND_DEPTH;
         pend_used++;
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is 0x%02h, expected 0x%02h", name, got, want));
      end
   endtask

   // Thompson construction on the shadow state; every new edge becomes one expected record.
   task automatic apply_request(input logic kind, input logic [7:0] sym);
      rsp_type    rec;
      rsp_type    made [4];
      int         made_n;
      logic [8:0] s;
      logic [8:0] e;
      logic [8:0] a_s;
      logic [8:0] a_f;
      logic [8:0] b_s;
      logic [8:0] b_f;
      made_n = 0;
      s = next_free[8:0];
      e = s + 9'd1;
      if (kind) begin
         rec          = '0;
         rec.rec_type = REC_DONE;
         if (build_error != ST_OK) begin
            rec.status = build_error;
         end else if (frag_count == 0) begin
            rec.status = ST_EMPTY;
         end else if (frag_count != 1) begin
            rec.status = ST_LEFTOVER;
         end else begin
            rec.status      = ST_OK;
            rec.start_state = frag_start[0][7:0];
            rec.final_state = frag_final[0][7:0];
         end
         made[0] = rec;
         made_n  = 1;
         statuses[rec.status] = 1'b1;
         dones_made++;
         clear_model();
      end else if (build_error == ST_OK) begin
         if (frag_count >= 1) begin
            b_s = frag_start[frag_count - 1];
            b_f = frag_final[frag_count - 1];
         end
         if (frag_count >= 2) begin
            a_s = frag_start[frag_count - 2];
            a_f = frag_final[frag_count - 2];
         end
         case (sym)
            SYM_CAT: begin
               if (frag_count < 2) begin
                  build_error = ST_UNDERFLOW;
               end else begin
                  made[0] = edge_record(a_f, b_s, 8'd0, 1'b1);
                  made_n  = 1;
                  frag_count--;
                  frag_start[frag_count - 1] = a_s;
                  frag_final[frag_count - 1] = b_f;
               end
            end
            SYM_ALT: begin
               if (frag_count < 2) begin
                  build_error = ST_UNDERFLOW;
               end else if (next_free + 2 > NFAB_MAX_STATES) begin
                  build_error = ST_NOROOM;
               end else begin
                  next_free += 2;
                  made[0] = edge_record(s, a_s, 8'd0, 1'b1);
                  made[1] = edge_record(s, b_s, 8'd0, 1'b1);
                  made[2] = edge_record(a_f, e, 8'd0, 1'b1);
                  made[3] = edge_record(b_f, e, 8'd0, 1'b1);
                  made_n  = 4;
                  frag_count--;
                  frag_start[frag_count - 1] = s;
                  frag_final[frag_count - 1] = e;
               end
            end
            SYM_STAR: begin
               if (frag_count < 1) begin
                  build_error = ST_UNDERFLOW;
               end else if (next_free + 2 > NFAB_MAX_STATES) begin
                  build_error = ST_NOROOM;
               end else begin
                  next_free += 2;
                  made[0] = edge_record(s, b_s, 8'd0, 1'b1);
                  made[1] = edge_record(s, e, 8'd0, 1'b1);
                  made[2] = edge_record(b_f, b_s, 8'd0, 1'b1);
                  made[3] = edge_record(b_f, e, 8'd0, 1'b1);
                  made_n  = 4;
                  frag_start[frag_count - 1] = s;
                  frag_final[frag_count - 1] = e;
               end
            end
            default: begin
               if (next_free + 2 > NFAB_MAX_STATES || frag_count >= NFAB_STACK_DEPTH) begin
                  build_error = ST_NOROOM;
               end else begin
                  next_free += 2;
                  made[0] = edge_record(s, e, sym, 1'b0);
                  made_n  = 1;
                  frag_start[frag_count] = s;
                  frag_final[frag_count] = e;
                  frag_count++;
               end
            end
         endcase
      end
      if (made_n > 0) begin
         made[made_n - 1].last = 1'b1;
      end
      for (int i = 0; i < made_n; i++) begin
         if (made[i].rec_type == REC_EDGE) edges_made++;
         add_expected(made[i]);
      end
   endtask

   task automatic compare_record();
      rsp_type want;
      if (pend_used == 0) begin
         report_mismatch($sformatf("arrived with nothing expected (rec_type %0b, status %0d)",
                                   rsp_rec_type, rsp_status));
      end else begin
         want      = pend_ring[pend_head];
         pend_head = (pend_head + 1) % PEND_DEPTH;
         pend_used--;
         check_field("rec_type", {7'd0, rsp_rec_type}, {7'd0, want.rec_type});
         check_field("from_state", rsp_from_state, want.from_state);
         check_field("to_state", rsp_to_state, want.to_state);
         check_field("label", rsp_label, want.label);
         check_field("is_epsilon", {7'd0, rsp_is_epsilon}, {7'd0, want.is_epsilon});
         check_field("start_state", rsp_start_state, want.start_state);
         check_field("final_state", rsp_final_state, want.final_state);
         check_field("status", {5'd0, rsp_status}, {5'd0, want.status});
         check_field("last", {7'd0, rsp_last}, {7'd0, want.last});
      end
      record_no++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         pend_head = 0;
         pend_tail = 0;
         pend_used = 0;
      end else begin
         // A record can never come from a request taken at the same edge.
         if (rsp_valid && rsp_ready) compare_record();
         if (req_valid && req_ready) apply_request(req_kind, req_symbol);
      end
      mismatches  <= fail_count;
      pending     <= pend_used;
      edge_total  <= edges_made;
      done_total  <= dones_made;
      status_seen <= statuses;
   end

endmodule

>>> sim/postfix_regex_to_nfa_builder_top_tb.sv
// Testbench top for the NFA builder: drives postfix expressions and gives the verdict.
`timescale 1ns / 100ps

module postfix_regex_to_nfa_builder_top_tb import nfab_pkg::*; ();

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 210;
   localparam int DRAIN_CYCLES  = 24;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKED} rx_mode_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_kind;
   logic [7:0] req_symbol;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_rec_type;
   logic [7:0] rsp_from_state;
   logic [7:0] rsp_to_state;
   logic [7:0] rsp_label;
   logic       rsp_is_epsilon;
   logic [7:0] rsp_start_state;
   logic [7:0] rsp_final_state;
   logic [2:0] rsp_status;
   logic       rsp_last;

   int         mismatches;
   int         pending;
   int         edge_total;
   int         done_total;
   logic [4:0] status_seen;

   int         cycle_count = 0;
   int         sent_count  = 0;
   int         burst_left  = 0;

   postfix_regex_to_nfa_builder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_symbol      (req_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rec_type    (rsp_rec_type),
      .rsp_from_state  (rsp_from_state),
      .rsp_to_state    (rsp_to_state),
      .rsp_label       (rsp_label),
      .rsp_is_epsilon  (rsp_is_epsilon),
      .rsp_start_state (rsp_start_state),
      .rsp_final_state (rsp_final_state),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   nfab_record_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_symbol      (req_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rec_type    (rsp_rec_type),
      .rsp_from_state  (rsp_from_state),
      .rsp_to_state    (rsp_to_state),
      .rsp_label       (rsp_label),
      .rsp_is_epsilon  (rsp_is_epsilon),
      .rsp_start_state (rsp_start_state),
      .rsp_final_state (rsp_final_state),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .mismatches      (mismatches),
      .pending         (pending),
      .edge_total      (edge_total),
      .done_total      (done_total),
      .status_seen     (status_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d records outstanding.",
                  cycle_count, pending);
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: ready follows a mode that is chosen at random again after each random span.
   initial begin
      rx_mode_type mode;
      int          span;
      rsp_ready = 1'b0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 9) != 0);
               default:   rsp_ready <= ($urandom_range(0, 11) == 0);
            endcase
         end
      end
   end

   function automatic logic [7:0] random_literal();
      logic [7:0] sym;
      do begin
         sym = 8'($urandom_range(0, 255));
      end while (sym == SYM_CAT || sym == SYM_ALT || sym == SYM_STAR);
      return sym;
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input logic kind, input logic [7:0] sym);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid  <= 1'b0;
            req_kind   <= 1'($urandom_range(0, 1));
            req_symbol <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_symbol <= sym;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_symbol(input logic [7:0] sym);
      send_request(1'b0, sym);
   endtask

   task automatic end_expression();
      send_request(1'b1, 8'($urandom_range(0, 255)));
   endtask

   // Thirty-two literals fill the stack, the next one overflows it.
   task automatic fill_stack_expression();
      repeat (NFAB_STACK_DEPTH + 1) send_symbol(random_literal());
      repeat ($urandom_range(1, 3)) send_symbol(8'($urandom_range(0, 255)));
      end_expression();
   endtask

   // Keeps the stack shallow and uses up every state number, then asks for two more.
   task automatic exhaust_states_expression();
      int used;
      int depth;
      int pick;
      send_symbol(random_literal());
      used  = 2;
      depth = 1;
      while (used < NFAB_MAX_STATES) begin
         pick = $urandom_range(0, 3);
         if (depth >= 2 && pick == 0) begin
            send_symbol(SYM_CAT);
            depth--;
         end else if (depth >= 2 && pick == 1) begin
            send_symbol(SYM_ALT);
            depth--;
            used += 2;
         end else if (depth < 3 && pick == 2) begin
            send_symbol(random_literal());
            depth++;
            used += 2;
         end else begin
            send_symbol(SYM_STAR);
            used += 2;
         end
      end
      send_symbol(($urandom_range(0, 1) == 0) ? SYM_STAR : random_literal());
      send_symbol(8'($urandom_range(0, 255)));
      end_expression();
   endtask

   task automatic random_expression();
      int lits_left;
      int depth;
      int kind_pick;
      kind_pick = $urandom_range(0, 99);
      if (kind_pick < 75) begin
         lits_left = $urandom_range(1, 12);
         depth     = 0;
         while (lits_left > 0 || depth > 1) begin
            if (lits_left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
               send_symbol(random_literal());
               lits_left--;
               depth++;
            end else begin
               send_symbol(($urandom_range(0, 1) == 0) ? SYM_CAT : SYM_ALT);
               depth--;
            end
            if ($urandom_range(0, 3) == 0) send_symbol(SYM_STAR);
         end
      end else begin
         // Broken or noisy expression: operators show up far more often than by chance.
         repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
               0:       send_symbol(SYM_CAT);
               1:       send_symbol(SYM_ALT);
               2:       send_symbol(SYM_STAR);
               default: send_symbol(8'($urandom_range(0, 255)));
            endcase
         end
      end
      end_expression();
   endtask

   initial begin
      int directed_count;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_kind   = 1'b0;
      req_symbol = 8'd0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty expression.
      end_expression();
      // Extreme literal bytes under union and star.
      send_symbol(8'h00);
      send_symbol(8'hFF);
      send_symbol(SYM_ALT);
      send_symbol(SYM_STAR);
      end_expression();
      // The letter E is an ordinary literal.
      send_symbol("E");
      send_symbol(random_literal());
      send_symbol(SYM_CAT);
      end_expression();
      // Star with nothing on the stack.
      send_symbol(SYM_STAR);
      end_expression();
      // Concatenation underflow; the symbol after it is dropped.
      send_symbol(random_literal());
      send_symbol(SYM_CAT);
      send_symbol(random_literal());
      end_expression();
      // Union underflow.
      send_symbol(random_literal());
      send_symbol(SYM_ALT);
      end_expression();
      // Two fragments left at the end.
      send_symbol(random_literal());
      send_symbol(random_literal());
      end_expression();
      directed_count = sent_count;

      fill_stack_expression();
      exhaust_states_expression();
      while (sent_count - directed_count < RANDOM_ITEMS) random_expression();
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests; checked %0d edge records and %0d done records.",
               sent_count, edge_total, done_total);
      $display("Done statuses seen (noroom..ok): %05b, mismatches: %0d.",
               status_seen, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
